@@ design/unique_tag_set_defines.svh @@
// Assertion macros shared by the unique tag set RTL.
// No dependencies; the macros expect clk_i and rst_ni in the including scope.
`ifndef UNIQUE_TAG_SET_DEFINES_SVH
`define UNIQUE_TAG_SET_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define UTS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/uts_pkg.sv @@
// Types and codes of the unique tag set.
// No dependencies.
package uts_pkg;

  localparam int unsigned TagW   = 32;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned CountW = 7;

  typedef enum logic [FuncW-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_CLEAR  = 2'd3
  } uts_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_RESP
  } uts_state_e;

  typedef struct packed {
    logic ok;
    logic full_res;
  } uts_res_t;

endpackage

@@ design/uts_if.sv @@
// Handshake channels of the unique tag set: request and response.
// Depends on uts_pkg for the field widths.
interface uts_req_if import uts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [TagW-1:0]   tag;

  modport source (output valid, output func, output tag, input ready);
  modport sink (input valid, input func, input tag, output ready);
endinterface

interface uts_rsp_if import uts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic              full_res;
  logic [CountW-1:0] entry_count;

  modport source (output valid, output ok, output full_res, output entry_count, input ready);
  modport sink (input valid, input ok, input full_res, input entry_count, output ready);
endinterface

@@ design/unique_tag_set.sv @@
// Channel  | Dir | Fields                      | Role
// req_i    | in  | func, tag                   | operation and tag, one per transfer
// rsp_o    | out | ok, full_res, entry_count   | one result per accepted request
//
// Append, remove and check scan the store one entry a cycle through the single read
// port; the result then passes to the response state, and the sequencer goes back to
// idle before it takes the next request, so requests are handled one at a time.
// A remove that hits stops scanning at the match and shifts the later entries down,
// one per cycle. Clear empties the set in idle and goes straight to the response.
// Reset empties the set at once; the store itself is not cleared.
// A stalled response holds in the output register; the next request is taken meanwhile.
// Depends on uts_pkg, uts_if, uts_mem, uts_ctrl, uts_oreg and unique_tag_set_defines.svh.
`include "unique_tag_set_defines.svh"

module unique_tag_set import uts_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  uts_req_if.sink req_i,
  uts_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [TagW-1:0]  rd_data;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [TagW-1:0]  wr_data;
  logic             res_valid;
  logic             res_ready;
  uts_res_t         res;
  logic [CntW-1:0]  count;

  uts_mem #(
    .Depth (CAPACITY),
    .AddrW (AddrW),
    .DataW (TagW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  uts_ctrl #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .count_o     (count)
  );

  uts_oreg #(
    .CntW (CntW)
  ) u_oreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .count_i     (count),
    .rsp_o       (rsp_o)
  );

  `UTS_ASSERT_ALWAYS(a_count_bound, count <= CntW'(CAPACITY), "tag count exceeds capacity")
  `UTS_ASSERT_NEXT(a_one_at_a_time, req_i.valid && req_i.ready, !req_i.ready, "taken while busy")
  `UTS_ASSERT_ALWAYS(a_idle_no_write, !(req_i.ready && wr_en), "store written while idle")
  `UTS_ASSERT_ALWAYS(a_full_not_ok, !(res_valid && res.ok && res.full_res), "refused append marked ok")

endmodule

@@ design/uts_mem.sv @@
// Tag store: one write port and one read port with registered read data.
// No package dependencies.
module uts_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/uts_ctrl.sv @@
// Sequencer of the unique tag set: linear search, append, shift-down remove and clear.
// Depends on uts_pkg and uts_req_if; drives the tag store ports.
module uts_ctrl import uts_pkg::*; #(
  parameter int unsigned Capacity = 64,
  parameter int unsigned AddrW    = 6,
  parameter int unsigned CntW     = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  uts_req_if.sink          req_i,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [TagW-1:0]  rd_data_i,
  output logic             wr_en_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic [TagW-1:0]  wr_data_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output uts_res_t         res_o,
  output logic [CntW-1:0]  count_o
);

  uts_state_e       state_q, state_d;
  uts_func_e        func_q;
  logic [TagW-1:0]  tag_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_ptr_q, rd_ptr_d;
  logic             pend_q, pend_d;
  logic [AddrW-1:0] pend_idx_q, pend_idx_d;
  logic [CntW-1:0]  sh_rd_q, sh_rd_d;
  logic [AddrW-1:0] sh_wr_q, sh_wr_d;
  uts_res_t         res_q, res_d;
  logic             hit;
  logic             more;
  logic             sh_more;

  // A compare is only meaningful on the cycle after a read was issued.
  assign hit     = pend_q && (rd_data_i == tag_q);
  assign more    = (rd_ptr_q < count_q);
  assign sh_more = (sh_rd_q < count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    sh_rd_d     = sh_rd_q;
    sh_wr_d     = sh_wr_q;
    res_d       = res_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = rd_ptr_q[AddrW-1:0];
    wr_en_o     = 1'b0;
    wr_addr_o   = sh_wr_q;
    wr_data_o   = rd_data_i;
    req_i.ready = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          rd_ptr_d = '0;
          pend_d   = 1'b0;
          if (uts_func_e'(req_i.func) == OP_CLEAR) begin
            count_d = '0;
            res_d   = '{ok: 1'b1, full_res: 1'b0};
            state_d = ST_RESP;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          res_d   = '{ok: 1'b1, full_res: 1'b0};
          state_d = ST_RESP;
          if (func_q == OP_REMOVE) begin
            sh_wr_d = pend_idx_q;
            sh_rd_d = CntW'(pend_idx_q) + CntW'(1);
            pend_d  = 1'b0;
            state_d = ST_SHIFT;
          end
        end else if (more) begin
          rd_en_o    = 1'b1;
          rd_ptr_d   = rd_ptr_q + CntW'(1);
          pend_d     = 1'b1;
          pend_idx_d = rd_ptr_q[AddrW-1:0];
        end else if (!pend_q) begin
          // Whole set searched without a match.
          state_d = ST_RESP;
          res_d   = '{ok: 1'b0, full_res: 1'b0};
          if (func_q == OP_APPEND) begin
            if (count_q >= CntW'(Capacity)) begin
              res_d = '{ok: 1'b0, full_res: 1'b1};
            end else begin
              wr_en_o   = 1'b1;
              wr_addr_o = count_q[AddrW-1:0];
              wr_data_o = tag_q;
              count_d   = count_q + CntW'(1);
              res_d     = '{ok: 1'b1, full_res: 1'b0};
            end
          end
        end else begin
          pend_d = 1'b0;
        end
      end
      ST_SHIFT: begin
        // Read entry i+1 while the entry read last cycle is written one place lower.
        if (pend_q) begin
          wr_en_o = 1'b1;
          sh_wr_d = sh_wr_q + AddrW'(1);
        end
        if (sh_more) begin
          rd_en_o   = 1'b1;
          rd_addr_o = sh_rd_q[AddrW-1:0];
          sh_rd_d   = sh_rd_q + CntW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CntW'(1);
            state_d = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      rd_ptr_q <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      func_q <= uts_func_e'(req_i.func);
      tag_q  <= req_i.tag;
    end
    pend_idx_q <= pend_idx_d;
    sh_rd_q    <= sh_rd_d;
    sh_wr_q    <= sh_wr_d;
    res_q      <= res_d;
  end

  assign res_o   = res_q;
  assign count_o = count_q;

endmodule

@@ design/uts_oreg.sv @@
// Output register of the unique tag set: holds one result until its transfer.
// Depends on uts_pkg and uts_rsp_if.
module uts_oreg import uts_pkg::*; #(
  parameter int unsigned CntW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            res_valid_i,
  output logic            res_ready_o,
  input  uts_res_t        res_i,
  input  logic [CntW-1:0] count_i,
  uts_rsp_if.source       rsp_o
);

  logic              valid_q, valid_d;
  uts_res_t          res_q;
  logic [CountW-1:0] cnt_q;
  logic              load;

  assign res_ready_o = !valid_q || rsp_o.ready;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
      cnt_q <= CountW'(count_i);
    end
  end

  assign rsp_o.valid       = valid_q;
  assign rsp_o.ok          = res_q.ok;
  assign rsp_o.full_res    = res_q.full_res;
  assign rsp_o.entry_count = cnt_q;

endmodule
